/* src/field_inverse_p2519_defines.svh */
// assertion helpers for the field inverter
`ifndef FIELD_INVERSE_P2519_DEFINES_SVH
`define FIELD_INVERSE_P2519_DEFINES_SVH

// condition must hold in the same cycle
`define FINV_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the next cycle
`define FINV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/finv_pkg.sv */
package finv_pkg;

    localparam int unsigned FeW     = 251;
    localparam int unsigned LimbW   = 64;
    localparam int unsigned TopW    = 59;
    localparam int unsigned WordW   = 32;
    localparam int unsigned ExtW    = 256;
    localparam int unsigned ProdW   = 512;
    localparam int unsigned RedW    = 266;
    localparam int unsigned AccW    = 70;
    localparam int unsigned SlotW   = 4;
    localparam int unsigned Slots   = 16;
    localparam int unsigned RepW    = 7;
    localparam int unsigned PcW     = 5;
    localparam int unsigned LastCol = 14;

    // 2^251 - 9
    localparam logic [FeW-1:0] Prime = {FeW{1'b1}} - FeW'(8);

    localparam logic [SlotW-1:0] SlotX   = 4'd0;
    localparam logic [SlotW-1:0] SlotX2  = 4'd1;
    localparam logic [SlotW-1:0] SlotX3  = 4'd2;
    localparam logic [SlotW-1:0] SlotX5  = 4'd3;
    localparam logic [SlotW-1:0] SlotX10 = 4'd4;
    localparam logic [SlotW-1:0] SlotT   = 4'd5;
    localparam logic [SlotW-1:0] SlotK5  = 4'd6;
    localparam logic [SlotW-1:0] SlotK10 = 4'd7;
    localparam logic [SlotW-1:0] SlotK20 = 4'd8;
    localparam logic [SlotW-1:0] SlotK40 = 4'd9;
    localparam logic [SlotW-1:0] SlotK80 = 4'd10;

    typedef struct packed {
        logic [TopW-1:0]  in_limb3;
        logic [LimbW-1:0] in_limb2;
        logic [LimbW-1:0] in_limb1;
        logic [LimbW-1:0] in_limb0;
    } item_t;

    typedef struct packed {
        logic [TopW-1:0]  result_limb3;
        logic [LimbW-1:0] result_limb2;
        logic [LimbW-1:0] result_limb1;
        logic [LimbW-1:0] result_limb0;
    } result_t;

    typedef struct packed {
        logic [SlotW-1:0] dst;
        logic [SlotW-1:0] srca;
        logic [SlotW-1:0] srcb;
        logic [RepW-1:0]  reps;
        logic             last;
    } op_t;

    function automatic op_t mk_op(input logic [SlotW-1:0] d, input logic [SlotW-1:0] a,
                                  input logic [SlotW-1:0] b, input int r, input logic l);
        op_t o;
        o.dst  = d;
        o.srca = a;
        o.srcb = b;
        o.reps = RepW'(r);
        o.last = l;
        return o;
    endfunction

    // addition chain: dst = srca * srcb, repeated reps times
    function automatic op_t prog_op(input logic [PcW-1:0] pc);
        op_t o;
        unique case (pc)
            5'd0:  o = mk_op(SlotX2,  SlotX,   SlotX,   1,  1'b0);
            5'd1:  o = mk_op(SlotX3,  SlotX2,  SlotX,   1,  1'b0);
            5'd2:  o = mk_op(SlotX5,  SlotX3,  SlotX2,  1,  1'b0);
            5'd3:  o = mk_op(SlotX10, SlotX5,  SlotX5,  1,  1'b0);
            5'd4:  o = mk_op(SlotT,   SlotX10, SlotX10, 1,  1'b0);
            5'd5:  o = mk_op(SlotT,   SlotT,   SlotX10, 1,  1'b0);
            5'd6:  o = mk_op(SlotK5,  SlotT,   SlotX,   1,  1'b0);
            5'd7:  o = mk_op(SlotT,   SlotK5,  SlotK5,  1,  1'b0);
            5'd8:  o = mk_op(SlotT,   SlotT,   SlotT,   4,  1'b0);
            5'd9:  o = mk_op(SlotK10, SlotT,   SlotK5,  1,  1'b0);
            5'd10: o = mk_op(SlotT,   SlotK10, SlotK10, 1,  1'b0);
            5'd11: o = mk_op(SlotT,   SlotT,   SlotT,   9,  1'b0);
            5'd12: o = mk_op(SlotK20, SlotT,   SlotK10, 1,  1'b0);
            5'd13: o = mk_op(SlotT,   SlotK20, SlotK20, 1,  1'b0);
            5'd14: o = mk_op(SlotT,   SlotT,   SlotT,   19, 1'b0);
            5'd15: o = mk_op(SlotK40, SlotT,   SlotK20, 1,  1'b0);
            5'd16: o = mk_op(SlotT,   SlotK40, SlotK40, 1,  1'b0);
            5'd17: o = mk_op(SlotT,   SlotT,   SlotT,   39, 1'b0);
            5'd18: o = mk_op(SlotK80, SlotT,   SlotK40, 1,  1'b0);
            5'd19: o = mk_op(SlotT,   SlotK80, SlotK80, 1,  1'b0);
            5'd20: o = mk_op(SlotT,   SlotT,   SlotT,   79, 1'b0);
            5'd21: o = mk_op(SlotT,   SlotT,   SlotK80, 1,  1'b0);
            5'd22: o = mk_op(SlotT,   SlotT,   SlotT,   80, 1'b0);
            5'd23: o = mk_op(SlotT,   SlotT,   SlotK80, 1,  1'b0);
            5'd24: o = mk_op(SlotT,   SlotT,   SlotT,   5,  1'b0);
            5'd25: o = mk_op(SlotT,   SlotT,   SlotK5,  1,  1'b0);
            5'd26: o = mk_op(SlotT,   SlotT,   SlotT,   2,  1'b0);
            5'd27: o = mk_op(SlotT,   SlotT,   SlotX3,  1,  1'b0);
            5'd28: o = mk_op(SlotT,   SlotT,   SlotT,   4,  1'b0);
            5'd29: o = mk_op(SlotT,   SlotT,   SlotX5,  1,  1'b1);
            default: o = mk_op(SlotT, SlotT,   SlotT,   1,  1'b1);
        endcase
        return o;
    endfunction

endpackage

/* src/finv_ram.sv */
module finv_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/field_inverse_p2519.sv */
// inverter for the prime field modulo 2^251 - 9
// item channel (item_valid / item_stall / item) takes one element as four limbs,
// least significant first; the top limb holds bits 250..192. an element at or
// above the prime is reduced first, so zero and the prime itself give zero.
// result channel (result_valid / result_stall / result) returns e^(p-2) mod p,
// fully reduced, one result beat per item beat, in order.
// one element is worked at a time: 262 modular multiplications of a fixed
// addition chain, each made of temporary reads, 64 32x32 partial products on
// one multiplier, reduction and one write back.
// temporaries live in a 16-entry memory with registered read; every op reads
// its operands after the previous write has landed, so no forwarding is needed.
// the next item is accepted as soon as the last product is in the output
// register, even while that result is still stalled.
// a stalled result holds in the output register; the chain waits for it to
// drain before it loads a new result.
// reset clears the sequencer and the output valid; memory contents need none.
`include "field_inverse_p2519_defines.svh"

module field_inverse_p2519 (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  finv_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output finv_pkg::result_t result
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RDA  = 4'd1;
    localparam logic [3:0] S_RDB  = 4'd2;
    localparam logic [3:0] S_LDB  = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_RED  = 4'd5;
    localparam logic [3:0] S_FOLD = 4'd6;
    localparam logic [3:0] S_SUB  = 4'd7;
    localparam logic [3:0] S_WB   = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [finv_pkg::PcW-1:0]  pc_reg, pc_next;
    logic [finv_pkg::RepW-1:0] rep_reg, rep_next;
    logic [3:0] col_reg, col_next;
    logic [2:0] i_reg, i_next;
    logic [1:0] fold_reg, fold_next;
    logic       out_valid_reg, out_valid_next;

    logic [finv_pkg::FeW-1:0]   a_reg, a_next;
    logic [finv_pkg::FeW-1:0]   b_reg, b_next;
    logic [finv_pkg::AccW-1:0]  acc_reg, acc_next;
    logic [finv_pkg::ProdW-1:0] w_reg, w_next;
    logic [finv_pkg::RedW-1:0]  t_reg, t_next;
    finv_pkg::result_t          res_reg, res_next;

    finv_pkg::op_t op;
    logic                        we;
    logic [finv_pkg::SlotW-1:0]  waddr, raddr;
    logic [finv_pkg::FeW-1:0]    wdata, rdata;

    logic [finv_pkg::FeW-1:0]    x_in;
    logic [finv_pkg::ExtW-1:0]   a_ext, b_ext;
    logic [2:0]                  imin, imax, j_idx, imin_nx;
    logic [3:0]                  col_inc;
    logic [finv_pkg::WordW-1:0]  aw, bw;
    logic [2*finv_pkg::WordW-1:0] prod;
    logic [finv_pkg::AccW-1:0]   sum;
    logic [finv_pkg::RedW-1:0]   hi_ext, top_ext;
    logic                        in_beat, out_beat, out_load;

    assign op = finv_pkg::prog_op(pc_reg);

    finv_ram #(
        .Width (finv_pkg::FeW),
        .Depth (finv_pkg::Slots)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign item_stall   = (state_reg != S_IDLE);
    assign in_beat      = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign result       = res_reg;
    assign out_beat     = out_valid_reg && !result_stall;
    assign out_load     = (state_reg == S_OUT) && (!out_valid_reg || !result_stall);

    assign x_in = {item.in_limb3, item.in_limb2, item.in_limb1, item.in_limb0};

    // column bounds for product scanning
    assign imin    = (col_reg > 4'd7) ? 3'(col_reg - 4'd7) : 3'd0;
    assign imax    = (col_reg > 4'd7) ? 3'd7 : col_reg[2:0];
    assign j_idx   = 3'(col_reg - {1'b0, i_reg});
    assign col_inc = col_reg + 4'd1;
    assign imin_nx = (col_inc > 4'd7) ? 3'(col_inc - 4'd7) : 3'd0;

    assign a_ext = {{(finv_pkg::ExtW - finv_pkg::FeW){1'b0}}, a_reg};
    assign b_ext = {{(finv_pkg::ExtW - finv_pkg::FeW){1'b0}}, b_reg};
    assign aw    = a_ext[i_reg * finv_pkg::WordW +: finv_pkg::WordW];
    assign bw    = b_ext[j_idx * finv_pkg::WordW +: finv_pkg::WordW];
    assign prod  = aw * bw;
    assign sum   = acc_reg + finv_pkg::AccW'(prod);

    assign hi_ext  = finv_pkg::RedW'(w_reg[finv_pkg::ProdW-1:finv_pkg::ExtW]);
    assign top_ext = finv_pkg::RedW'(t_reg[finv_pkg::RedW-1:finv_pkg::FeW]);

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        rep_next       = rep_reg;
        col_next       = col_reg;
        i_next         = i_reg;
        fold_next      = fold_reg;
        out_valid_next = out_valid_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        acc_next       = acc_reg;
        w_next         = w_reg;
        t_next         = t_reg;
        res_next       = res_reg;
        we             = 1'b0;
        waddr          = op.dst;
        wdata          = t_reg[finv_pkg::FeW-1:0];
        raddr          = op.srca;

        if (out_beat)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                waddr = finv_pkg::SlotX;
                wdata = (x_in >= finv_pkg::Prime) ? (x_in - finv_pkg::Prime) : x_in;
                if (in_beat)
                begin
                    we         = 1'b1;
                    pc_next    = '0;
                    rep_next   = '0;
                    state_next = S_RDA;
                end
            end
            S_RDA:
            begin
                raddr      = op.srca;
                state_next = S_RDB;
            end
            S_RDB:
            begin
                raddr      = op.srcb;
                a_next     = rdata;
                state_next = S_LDB;
            end
            S_LDB:
            begin
                b_next     = rdata;
                col_next   = '0;
                i_next     = '0;
                acc_next   = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (i_reg == imax)
                begin
                    if (col_reg == 4'(finv_pkg::LastCol))
                    begin
                        // last column also carries out the top word
                        w_next     = {sum[2*finv_pkg::WordW-1:0],
                                      w_reg[finv_pkg::ProdW-1:2*finv_pkg::WordW]};
                        state_next = S_RED;
                    end
                    else
                    begin
                        w_next   = {sum[finv_pkg::WordW-1:0],
                                    w_reg[finv_pkg::ProdW-1:finv_pkg::WordW]};
                        acc_next = sum >> finv_pkg::WordW;
                        col_next = col_inc;
                        i_next   = imin_nx;
                    end
                end
                else
                begin
                    acc_next = sum;
                    i_next   = i_reg + 3'd1;
                end
            end
            S_RED:
            begin
                // 2^256 == 288 mod p
                t_next = finv_pkg::RedW'(w_reg[finv_pkg::ExtW-1:0])
                       + (hi_ext << 8) + (hi_ext << 5);
                fold_next  = '0;
                state_next = S_FOLD;
            end
            S_FOLD:
            begin
                // 2^251 == 9 mod p
                t_next = finv_pkg::RedW'(t_reg[finv_pkg::FeW-1:0])
                       + (top_ext << 3) + top_ext;
                fold_next = fold_reg + 2'd1;
                if (fold_reg == 2'd2)
                begin
                    state_next = S_SUB;
                end
            end
            S_SUB:
            begin
                if (t_reg >= finv_pkg::RedW'(finv_pkg::Prime))
                begin
                    t_next = t_reg - finv_pkg::RedW'(finv_pkg::Prime);
                end
                state_next = S_WB;
            end
            S_WB:
            begin
                we = 1'b1;
                if (rep_reg + finv_pkg::RepW'(1) < op.reps)
                begin
                    rep_next   = rep_reg + finv_pkg::RepW'(1);
                    state_next = S_RDA;
                end
                else if (op.last)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    rep_next   = '0;
                    pc_next    = pc_reg + finv_pkg::PcW'(1);
                    state_next = S_RDA;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    res_next.result_limb0 = t_reg[63:0];
                    res_next.result_limb1 = t_reg[127:64];
                    res_next.result_limb2 = t_reg[191:128];
                    res_next.result_limb3 = t_reg[250:192];
                    out_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            rep_reg       <= '0;
            col_reg       <= '0;
            i_reg         <= '0;
            fold_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            rep_reg       <= rep_next;
            col_reg       <= col_next;
            i_reg         <= i_next;
            fold_reg      <= fold_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        w_reg   <= w_next;
        t_reg   <= t_next;
        res_reg <= res_next;
    end

    `FINV_ASSERT_SAME(a_busy_stalls, state_reg != S_IDLE, item_stall, "busy without stall")
    `FINV_ASSERT_SAME(a_col_bounds, state_reg == S_MUL, (i_reg >= imin) && (i_reg <= imax), "bad index")
    `FINV_ASSERT_SAME(a_wb_reduced, state_reg == S_WB, t_reg < finv_pkg::RedW'(finv_pkg::Prime), "not reduced")
    `FINV_ASSERT_NEXT(a_out_loads, out_load, result_valid, "result not presented")

endmodule

/* tb/sv/field_inverse_p2519_chk.sv */
`timescale 1ns / 100ps

module field_inverse_p2519_chk (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  finv_pkg::item_t   item,
    input  logic              result_valid,
    input  logic              result_stall,
    input  finv_pkg::result_t result,
    output int                errors,
    output int                pending
);

    localparam int unsigned FeW = finv_pkg::FeW;
    localparam int unsigned LimbW = finv_pkg::LimbW;
    localparam logic [FeW-1:0] FieldP = {FeW{1'b1}} - FeW'(8);

    finv_pkg::result_t inverse_q[$];

    function automatic logic [FeW-1:0] mod_mul(input logic [FeW-1:0] a,
                                               input logic [FeW-1:0] b);
        logic [2*FeW-1:0] prod;
        prod = {{FeW{1'b0}}, a} * {{FeW{1'b0}}, b};
        prod = prod % {{FeW{1'b0}}, FieldP};
        return prod[FeW-1:0];
    endfunction

    function automatic logic [FeW-1:0] mod_sqr_n(input logic [FeW-1:0] a, input int n);
        logic [FeW-1:0] r;
        r = a;
        for (int i = 0; i < n; i++)
            r = mod_mul(r, r);
        return r;
    endfunction

    // x^(p-2) via the fixed addition chain
    function automatic finv_pkg::result_t field_inverse(input finv_pkg::item_t v);
        logic [FeW-1:0] x, x2, x3, x5, x10, t, k5, k10, k20, k40, k80;
        finv_pkg::result_t r;
        x = {v.in_limb3, v.in_limb2, v.in_limb1, v.in_limb0};
        if (x >= FieldP)
            x = x - FieldP;
        x2  = mod_mul(x, x);
        x3  = mod_mul(x2, x);
        x5  = mod_mul(x3, x2);
        x10 = mod_mul(x5, x5);
        t   = mod_mul(x10, x10);
        t   = mod_mul(t, x10);
        k5  = mod_mul(t, x);
        k10 = mod_mul(mod_sqr_n(k5, 5), k5);
        k20 = mod_mul(mod_sqr_n(k10, 10), k10);
        k40 = mod_mul(mod_sqr_n(k20, 20), k20);
        k80 = mod_mul(mod_sqr_n(k40, 40), k40);
        t   = mod_mul(mod_sqr_n(k80, 80), k80);
        t   = mod_mul(mod_sqr_n(t, 80), k80);
        t   = mod_mul(mod_sqr_n(t, 5), k5);
        t   = mod_mul(mod_sqr_n(t, 2), x3);
        t   = mod_mul(mod_sqr_n(t, 4), x5);
        r   = t;
        return r;
    endfunction

    task automatic report(input string what, input logic [LimbW-1:0] got,
                          input logic [LimbW-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        finv_pkg::result_t want;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                inverse_q.push_back(field_inverse(item));
            if (result_valid && !result_stall)
            begin
                if (inverse_q.size() == 0)
                begin
                    $display("unexpected result beat at %0t", $realtime);
                    errors++;
                end
                else
                begin
                    want = inverse_q.pop_front();
                    if (result.result_limb0 !== want.result_limb0)
                        report("result_limb0", result.result_limb0, want.result_limb0);
                    if (result.result_limb1 !== want.result_limb1)
                        report("result_limb1", result.result_limb1, want.result_limb1);
                    if (result.result_limb2 !== want.result_limb2)
                        report("result_limb2", result.result_limb2, want.result_limb2);
                    if (result.result_limb3 !== want.result_limb3)
                        report("result_limb3", LimbW'(result.result_limb3),
                               LimbW'(want.result_limb3));
                end
            end
        end
        pending = inverse_q.size();
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam int NumItems = 140;
    localparam longint CycleLimit = 12_000_000;
    localparam int unsigned LimbW = finv_pkg::LimbW;
    localparam int unsigned TopW = finv_pkg::TopW;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    finv_pkg::item_t   item;
    logic              result_valid;
    logic              result_stall;
    finv_pkg::result_t result;
    int      errors;
    int      pending;
    longint  cycles;

    field_inverse_p2519 dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    field_inverse_p2519_chk chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .errors       (errors),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 2) == 0)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 300);
        return $urandom_range(1, 4);
    endfunction

    function automatic logic [LimbW-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic finv_pkg::item_t rand_element();
        finv_pkg::item_t v;
        int    kind;
        kind = $urandom_range(0, 19);
        v.in_limb0 = rand64();
        v.in_limb1 = rand64();
        v.in_limb2 = rand64();
        v.in_limb3 = TopW'(rand64());
        if (kind < 3)
        begin
            // small values
            v.in_limb1 = '0;
            v.in_limb2 = '0;
            v.in_limb3 = '0;
            if (kind == 0)
                v.in_limb0 = LimbW'($urandom_range(0, 20));
        end
        else if (kind < 6)
        begin
            // around the prime, below and above it
            v.in_limb1 = '1;
            v.in_limb2 = '1;
            v.in_limb3 = '1;
            v.in_limb0 = {60'hFFFFFFFFFFFFFFF, 4'($urandom_range(0, 15))};
        end
        return v;
    endfunction

    task automatic send(input finv_pkg::item_t v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= v;
        do @(posedge clk); while (item_stall);
    endtask

    function automatic finv_pkg::item_t mk_item(input logic [TopW-1:0] l3,
                                                input logic [LimbW-1:0] l2,
                                                input logic [LimbW-1:0] l1,
                                                input logic [LimbW-1:0] l0);
        finv_pkg::item_t v;
        v.in_limb3 = l3;
        v.in_limb2 = l2;
        v.in_limb1 = l1;
        v.in_limb0 = l0;
        return v;
    endfunction

    finv_pkg::item_t directed[$];

    // result side backpressure
    initial
    begin
        int len;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            len = $urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : $urandom_range(1, 6);
            if ($urandom_range(0, 15) == 0)
                len = $urandom_range(200, 2000);
            result_stall <= ($urandom_range(0, 2) == 0);
            repeat (len) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        directed = '{
            mk_item('0, '0, '0, '0),
            mk_item('0, '0, '0, 64'd1),
            mk_item('0, '0, '0, 64'd2),
            mk_item('1, '1, '1, 64'hFFFF_FFFF_FFFF_FFF6),
            mk_item('1, '1, '1, 64'hFFFF_FFFF_FFFF_FFF7),
            mk_item('1, '1, '1, 64'hFFFF_FFFF_FFFF_FFF8),
            mk_item('1, '1, '1, '1),
            mk_item('1, '0, '0, '0),
            mk_item('0, '0, '0, '1),
            mk_item(TopW'({30{2'b10}}), {32{2'b10}}, {32{2'b10}}, {32{2'b10}}),
            mk_item(TopW'({30{2'b01}}), {32{2'b01}}, {32{2'b01}}, {32{2'b01}}),
            mk_item(59'd1, '0, '0, '0),
            mk_item('0, 64'd1, '0, '0),
            mk_item('0, '0, 64'd1, '0)
        };
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send(directed[i]);
        for (int i = directed.size(); i < NumItems; i++)
            send(rand_element());
        item_valid <= 1'b0;
        // let the checker take the last beat before looking at its queue
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
